/* design/gds_pkg.sv */
// Shared types, constants and helper functions for the guarded drive supervisor.
`default_nettype none

package gds_pkg;

    localparam int CLIFF_W   = 12;
    localparam int DIST_W    = 16;
    localparam int TRAV_W    = 18;
    localparam int BACKUP_W  = 15;
    localparam int SPEED_W   = 9;
    localparam int WHEEL_W   = 10;
    localparam int OUTCOME_W = 3;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 3;

    localparam logic [CLIFF_W-1:0]  CLIFF_LOW_RST       = 12'd500;
    localparam logic [CLIFF_W-1:0]  CLIFF_HIGH_RST      = 12'd2500;
    localparam logic [BACKUP_W-1:0] BACKUP_DISTANCE_RST = 15'd150;
    localparam logic [SPEED_W-1:0]  FORWARD_SPEED_RST   = 9'd150;
    localparam logic [SPEED_W-1:0]  REVERSE_SPEED_RST   = 9'd175;
    localparam logic [SPEED_W-1:0]  SPEED_MAX           = 9'd500;

    localparam logic signed [TRAV_W-1:0] TRAV_MAX = 18'sh1FFFF;
    localparam logic signed [TRAV_W-1:0] TRAV_MIN = 18'sh20000;

    localparam logic [IDX_W-1:0] REG_CLIFF_LOW       = 3'd0;
    localparam logic [IDX_W-1:0] REG_CLIFF_HIGH      = 3'd1;
    localparam logic [IDX_W-1:0] REG_BACKUP_DISTANCE = 3'd2;
    localparam logic [IDX_W-1:0] REG_FORWARD_SPEED   = 3'd3;
    localparam logic [IDX_W-1:0] REG_REVERSE_SPEED   = 3'd4;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [OUTCOME_W-1:0] OC_NONE       = 3'd0;
    localparam logic [OUTCOME_W-1:0] OC_REACHED    = 3'd1;
    localparam logic [OUTCOME_W-1:0] OC_BUMP_LEFT  = 3'd2;
    localparam logic [OUTCOME_W-1:0] OC_BUMP_RIGHT = 3'd3;
    localparam logic [OUTCOME_W-1:0] OC_CLIFF_LEFT = 3'd4;
    localparam logic [OUTCOME_W-1:0] OC_CLIFF_RIGHT = 3'd5;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FWD,
        PH_BACK
    } phase_t;

    typedef struct packed {
        logic [CLIFF_W-1:0]  cliff_low;
        logic [CLIFF_W-1:0]  cliff_high;
        logic [BACKUP_W-1:0] backup_distance;
        logic [SPEED_W-1:0]  forward_speed;
        logic [SPEED_W-1:0]  reverse_speed;
    } cfg_t;

    typedef struct packed {
        logic                     op;
        logic signed [DIST_W-1:0] target_distance;
        logic signed [DIST_W-1:0] distance_delta;
        logic                     bump_left;
        logic                     bump_right;
        logic [CLIFF_W-1:0]       cliff_front_left;
        logic [CLIFF_W-1:0]       cliff_side_left;
        logic [CLIFF_W-1:0]       cliff_front_right;
        logic [CLIFF_W-1:0]       cliff_side_right;
    } item_t;

    typedef struct packed {
        logic signed [WHEEL_W-1:0] wheel_speed;
        logic [OUTCOME_W-1:0]      outcome;
        logic                      finished;
    } result_t;

    function automatic logic outside_window(
        input logic [CLIFF_W-1:0] sig,
        input logic [CLIFF_W-1:0] lo,
        input logic [CLIFF_W-1:0] hi
    );
        return (sig > hi) || (sig < lo);
    endfunction

    function automatic logic [SPEED_W-1:0] clip_speed(input logic [SPEED_W-1:0] s);
        return (s > SPEED_MAX) ? SPEED_MAX : s;
    endfunction

endpackage

`default_nettype wire

/* design/gds_cfg.sv */
// Configuration register file behind the APB-style port.
`default_nettype none

module gds_cfg
    import gds_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t             cfg_reg;
    logic             wr_en;
    logic [IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cliff_low       <= CLIFF_LOW_RST;
            cfg_reg.cliff_high      <= CLIFF_HIGH_RST;
            cfg_reg.backup_distance <= BACKUP_DISTANCE_RST;
            cfg_reg.forward_speed   <= FORWARD_SPEED_RST;
            cfg_reg.reverse_speed   <= REVERSE_SPEED_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_CLIFF_LOW:       cfg_reg.cliff_low       <= pwdata[CLIFF_W-1:0];
                REG_CLIFF_HIGH:      cfg_reg.cliff_high      <= pwdata[CLIFF_W-1:0];
                REG_BACKUP_DISTANCE: cfg_reg.backup_distance <= pwdata[BACKUP_W-1:0];
                REG_FORWARD_SPEED:   cfg_reg.forward_speed   <= pwdata[SPEED_W-1:0];
                REG_REVERSE_SPEED:   cfg_reg.reverse_speed   <= pwdata[SPEED_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_CLIFF_LOW:       prdata = DATA_W'(cfg_reg.cliff_low);
            REG_CLIFF_HIGH:      prdata = DATA_W'(cfg_reg.cliff_high);
            REG_BACKUP_DISTANCE: prdata = DATA_W'(cfg_reg.backup_distance);
            REG_FORWARD_SPEED:   prdata = DATA_W'(cfg_reg.forward_speed);
            REG_REVERSE_SPEED:   prdata = DATA_W'(cfg_reg.reverse_speed);
            default:             prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* design/gds_step.sv */
// Drive state machine: holds move state and works out the result for one item.
`default_nettype none

module gds_step
    import gds_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  advance,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output result_t    result
);

    phase_t                   phase_reg, phase_next;
    logic signed [TRAV_W-1:0] travelled_reg, travelled_next;
    logic signed [DIST_W-1:0] target_reg, target_next;
    logic [OUTCOME_W-1:0]     outcome_reg, outcome_next;

    logic                       cliff_l, cliff_r;
    logic [OUTCOME_W-1:0]       hazard;
    logic signed [TRAV_W:0]     sum_wide;
    logic signed [TRAV_W-1:0]   sum_sat;
    logic signed [TRAV_W-1:0]   target_ext;
    logic signed [TRAV_W-1:0]   backup_ext;
    logic signed [WHEEL_W-1:0]  fwd_speed;
    logic signed [WHEEL_W-1:0]  rev_speed;

    assign cliff_l = outside_window(item.cliff_front_left, cfg.cliff_low, cfg.cliff_high)
                  || outside_window(item.cliff_side_left, cfg.cliff_low, cfg.cliff_high);
    assign cliff_r = outside_window(item.cliff_front_right, cfg.cliff_low, cfg.cliff_high)
                  || outside_window(item.cliff_side_right, cfg.cliff_low, cfg.cliff_high);

    assign sum_wide   = (TRAV_W+1)'(travelled_reg) + (TRAV_W+1)'(item.distance_delta);
    assign target_ext = TRAV_W'(target_reg);
    assign backup_ext = $signed({{(TRAV_W-BACKUP_W){1'b0}}, cfg.backup_distance});
    assign fwd_speed  = $signed({1'b0, clip_speed(cfg.forward_speed)});
    assign rev_speed  = -$signed({1'b0, clip_speed(cfg.reverse_speed)});

    always_comb
    begin
        if (sum_wide > (TRAV_W+1)'(TRAV_MAX))
        begin
            sum_sat = TRAV_MAX;
        end
        else if (sum_wide < (TRAV_W+1)'(TRAV_MIN))
        begin
            sum_sat = TRAV_MIN;
        end
        else
        begin
            sum_sat = sum_wide[TRAV_W-1:0];
        end
    end

    always_comb
    begin
        priority if (item.bump_left)
        begin
            hazard = OC_BUMP_LEFT;
        end
        else if (item.bump_right)
        begin
            hazard = OC_BUMP_RIGHT;
        end
        else if (cliff_l)
        begin
            hazard = OC_CLIFF_LEFT;
        end
        else if (cliff_r)
        begin
            hazard = OC_CLIFF_RIGHT;
        end
        else
        begin
            hazard = OC_NONE;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        travelled_next = travelled_reg;
        target_next    = target_reg;
        outcome_next   = outcome_reg;
        if (item.op == OP_START)
        begin
            target_next    = item.target_distance;
            travelled_next = '0;
            if (item.target_distance <= 0)
            begin
                outcome_next = OC_REACHED;
                phase_next   = PH_IDLE;
            end
            else
            begin
                outcome_next = OC_NONE;
                phase_next   = PH_FWD;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_FWD:
                begin
                    travelled_next = sum_sat;
                    if (hazard != OC_NONE)
                    begin
                        outcome_next   = hazard;
                        travelled_next = backup_ext;
                        phase_next     = (backup_ext > 0) ? PH_BACK : PH_IDLE;
                    end
                    else if (sum_sat >= target_ext)
                    begin
                        outcome_next = OC_REACHED;
                        phase_next   = PH_IDLE;
                    end
                end
                PH_BACK:
                begin
                    travelled_next = sum_sat;
                    if (cliff_l || cliff_r || (sum_sat <= 0))
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        result.outcome  = outcome_next;
        result.finished = (phase_next == PH_IDLE);
        unique case (phase_next)
            PH_FWD:  result.wheel_speed = fwd_speed;
            PH_BACK: result.wheel_speed = rev_speed;
            default: result.wheel_speed = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            travelled_reg <= '0;
            target_reg    <= '0;
            outcome_reg   <= OC_NONE;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            travelled_reg <= travelled_next;
            target_reg    <= target_next;
            outcome_reg   <= outcome_next;
        end
    end

endmodule

`default_nettype wire

/* design/guarded_drive_supervisor.sv */
// Guarded drive supervisor: input register, drive state machine, result register.
// An accepted item waits in the input register until its result enters the result register.
// One item per cycle unless out_ready stalls; the update is a saturating add and a few compares.
// The input side keeps accepting while a finished result waits, unless both registers are full.
// Reset (rst_n low, asynchronous) empties both registers, sets phase idle, travelled,
// target and outcome to zero and loads the configuration defaults.
`default_nettype none

module guarded_drive_supervisor
    import gds_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      op,
    input  wire logic signed [DIST_W-1:0]  target_distance,
    input  wire logic signed [DIST_W-1:0]  distance_delta,
    input  wire logic                      bump_left,
    input  wire logic                      bump_right,
    input  wire logic [CLIFF_W-1:0]        cliff_front_left,
    input  wire logic [CLIFF_W-1:0]        cliff_side_left,
    input  wire logic [CLIFF_W-1:0]        cliff_front_right,
    input  wire logic [CLIFF_W-1:0]        cliff_side_right,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [WHEEL_W-1:0]      wheel_speed,
    output logic [OUTCOME_W-1:0]           outcome,
    output logic                           finished,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ADDR_W-1:0]         paddr,
    input  wire logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]              prdata,
    output logic                           pready
);

    cfg_t    cfg;
    item_t   item_in;
    item_t   item_reg;
    result_t result;
    result_t result_reg;
    logic    in_valid_reg, in_valid_next;
    logic    out_valid_reg, out_valid_next;
    logic    advance;
    logic    accept;

    assign item_in.op                = op;
    assign item_in.target_distance   = target_distance;
    assign item_in.distance_delta    = distance_delta;
    assign item_in.bump_left         = bump_left;
    assign item_in.bump_right        = bump_right;
    assign item_in.cliff_front_left  = cliff_front_left;
    assign item_in.cliff_side_left   = cliff_side_left;
    assign item_in.cliff_front_right = cliff_front_right;
    assign item_in.cliff_side_right  = cliff_side_right;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        priority if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_comb
    begin
        priority if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_in;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    gds_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gds_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign out_valid   = out_valid_reg;
    assign wheel_speed = result_reg.wheel_speed;
    assign outcome     = result_reg.outcome;
    assign finished    = result_reg.finished;

endmodule

`default_nettype wire

/* design/gds_checker.sv */
// Port-level checker for the guarded drive supervisor, bound to the top level.
`default_nettype none

module gds_checker
    import gds_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     out_valid,
    input wire logic                     out_ready,
    input wire logic signed [WHEEL_W-1:0] wheel_speed,
    input wire logic [OUTCOME_W-1:0]     outcome,
    input wire logic                     finished
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(wheel_speed)
            && $stable(outcome) && $stable(finished))
        else $error("stalled result item changed");

    a_finished_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> wheel_speed == '0)
        else $error("finished item commands a non-zero speed");

    a_running_not_reached: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !finished |-> outcome != OC_REACHED)
        else $error("running move reports target reached");

    a_backup_reverses: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !finished && (outcome != OC_NONE) |-> wheel_speed <= 0)
        else $error("backup run commands forward speed");

    a_forward_not_reverse: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !finished && (outcome == OC_NONE) |-> wheel_speed >= 0)
        else $error("forward run commands reverse speed");

endmodule

bind guarded_drive_supervisor gds_checker u_gds_checker (.*);

`default_nettype wire

/* tb/sv/drive_command_checker.sv */
// Drive command checker: predicts each result (wheel speed, outcome, finished) from the accepted items and compares.
module drive_command_checker
    import gds_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic                      op,
    input  logic signed [DIST_W-1:0]  target_distance,
    input  logic signed [DIST_W-1:0]  distance_delta,
    input  logic                      bump_left,
    input  logic                      bump_right,
    input  logic [CLIFF_W-1:0]        cliff_front_left,
    input  logic [CLIFF_W-1:0]        cliff_side_left,
    input  logic [CLIFF_W-1:0]        cliff_front_right,
    input  logic [CLIFF_W-1:0]        cliff_side_right,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic signed [WHEEL_W-1:0] wheel_speed,
    input  logic [OUTCOME_W-1:0]      outcome,
    input  logic                      finished,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic                      pready,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output int                        mismatches,
    output int                        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    cfg_t                      cfg;
    phase_t                    drive_phase;
    logic signed [TRAV_W-1:0]  dist_sum;
    logic signed [DIST_W-1:0]  target_mm;
    logic [OUTCOME_W-1:0]      held_outcome;
    result_t                   commands_due [$];
    result_t                   due;
    item_t                     item_now;
    int                        mismatch_count = 0;
    int                        results_checked = 0;

    assign item_now = {op, target_distance, distance_delta, bump_left, bump_right,
                       cliff_front_left, cliff_side_left, cliff_front_right, cliff_side_right};
    assign mismatches = mismatch_count;

    task automatic note_mismatch(input string what, input int got, input int expected_val);
        if (mismatch_count < 100)
            $display("MISMATCH result %0d %s: got %0d, expected %0d",
                     results_checked, what, got, expected_val);
        mismatch_count++;
    endtask

    function automatic logic beyond_window(input logic [CLIFF_W-1:0] sig);
        return (sig < cfg.cliff_low) || (sig > cfg.cliff_high);
    endfunction

    function automatic logic signed [WHEEL_W-1:0] limited_speed(input logic [SPEED_W-1:0] s);
        return (s > SPEED_MAX) ? $signed({1'b0, SPEED_MAX}) : $signed({1'b0, s});
    endfunction

    function automatic logic signed [TRAV_W-1:0] sum_clamped(
        input logic signed [DIST_W-1:0] delta
    );
        int total;
        total = int'(dist_sum) + int'(delta);
        if (total > int'(TRAV_MAX))
            total = int'(TRAV_MAX);
        if (total < int'(TRAV_MIN))
            total = int'(TRAV_MIN);
        return TRAV_W'(total);
    endfunction

    function automatic result_t command_for_item(input item_t it);
        logic signed [WHEEL_W-1:0] fwd;
        logic signed [WHEEL_W-1:0] rev;
        logic                      left_edge;
        logic                      right_edge;
        logic [OUTCOME_W-1:0]      code;
        result_t                   res;
        fwd = limited_speed(cfg.forward_speed);
        rev = -limited_speed(cfg.reverse_speed);
        left_edge = beyond_window(it.cliff_front_left) || beyond_window(it.cliff_side_left);
        right_edge = beyond_window(it.cliff_front_right) || beyond_window(it.cliff_side_right);
        res = '{'0, held_outcome, 1'b1};
        if (it.op == OP_START)
        begin
            target_mm = it.target_distance;
            dist_sum = '0;
            held_outcome = OC_NONE;
            if (target_mm <= 0)
            begin
                held_outcome = OC_REACHED;
                drive_phase = PH_IDLE;
                res = '{'0, OC_REACHED, 1'b1};
            end
            else
            begin
                drive_phase = PH_FWD;
                res = '{fwd, OC_NONE, 1'b0};
            end
        end
        else if (drive_phase == PH_FWD)
        begin
            dist_sum = sum_clamped(it.distance_delta);
            if (it.bump_left)
                code = OC_BUMP_LEFT;
            else if (it.bump_right)
                code = OC_BUMP_RIGHT;
            else if (left_edge)
                code = OC_CLIFF_LEFT;
            else if (right_edge)
                code = OC_CLIFF_RIGHT;
            else
                code = OC_NONE;
            if (code != OC_NONE)
            begin
                held_outcome = code;
                dist_sum = $signed({3'b000, cfg.backup_distance});
                if (dist_sum > 0)
                begin
                    drive_phase = PH_BACK;
                    res = '{rev, code, 1'b0};
                end
                else
                begin
                    drive_phase = PH_IDLE;
                    res = '{'0, code, 1'b1};
                end
            end
            else if (dist_sum >= target_mm)
            begin
                held_outcome = OC_REACHED;
                drive_phase = PH_IDLE;
                res = '{'0, OC_REACHED, 1'b1};
            end
            else
            begin
                res = '{fwd, held_outcome, 1'b0};
            end
        end
        else if (drive_phase == PH_BACK)
        begin
            dist_sum = sum_clamped(it.distance_delta);
            if (left_edge || right_edge || dist_sum <= 0)
            begin
                drive_phase = PH_IDLE;
                res = '{'0, held_outcome, 1'b1};
            end
            else
            begin
                res = '{rev, held_outcome, 1'b0};
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.cliff_low = CLIFF_LOW_RST;
            cfg.cliff_high = CLIFF_HIGH_RST;
            cfg.backup_distance = BACKUP_DISTANCE_RST;
            cfg.forward_speed = FORWARD_SPEED_RST;
            cfg.reverse_speed = REVERSE_SPEED_RST;
            drive_phase = PH_IDLE;
            dist_sum = '0;
            target_mm = '0;
            held_outcome = OC_NONE;
            commands_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_CLIFF_LOW:       cfg.cliff_low = pwdata[CLIFF_W-1:0];
                    REG_CLIFF_HIGH:      cfg.cliff_high = pwdata[CLIFF_W-1:0];
                    REG_BACKUP_DISTANCE: cfg.backup_distance = pwdata[BACKUP_W-1:0];
                    REG_FORWARD_SPEED:   cfg.forward_speed = pwdata[SPEED_W-1:0];
                    REG_REVERSE_SPEED:   cfg.reverse_speed = pwdata[SPEED_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                commands_due.push_back(command_for_item(item_now));
            if (out_valid && out_ready)
            begin
                if (commands_due.size() == 0)
                begin
                    note_mismatch("result with nothing due, wheel_speed", wheel_speed, 0);
                end
                else
                begin
                    due = commands_due.pop_front();
                    if (wheel_speed !== due.wheel_speed)
                        note_mismatch("wheel_speed", wheel_speed, due.wheel_speed);
                    if (outcome !== due.outcome)
                        note_mismatch("outcome", outcome, due.outcome);
                    if (finished !== due.finished)
                        note_mismatch("finished", finished, due.finished);
                end
                results_checked++;
            end
            outstanding <= commands_due.size();
        end
    end

endmodule

/* tb/sv/tb_guarded_drive_supervisor.sv */
// Testbench top for the guarded drive supervisor: clock, reset, item and register stimulus, verdict.
module tb_guarded_drive_supervisor;
    import gds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int SIGNAL_MAX = (1 << CLIFF_W) - 1;
    localparam int STALL_LIMIT = 4000;
    localparam int ITEM_BITS = $bits(item_t);

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      op = OP_START;
    logic signed [DIST_W-1:0]  target_distance = '0;
    logic signed [DIST_W-1:0]  distance_delta = '0;
    logic                      bump_left = 1'b0;
    logic                      bump_right = 1'b0;
    logic [CLIFF_W-1:0]        cliff_front_left = '0;
    logic [CLIFF_W-1:0]        cliff_side_left = '0;
    logic [CLIFF_W-1:0]        cliff_front_right = '0;
    logic [CLIFF_W-1:0]        cliff_side_right = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [WHEEL_W-1:0] wheel_speed;
    logic [OUTCOME_W-1:0]      outcome;
    logic                      finished;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [ADDR_W-1:0]         paddr = '0;
    logic [DATA_W-1:0]         pwdata = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    int mismatches;
    int outstanding;
    int items_sent = 0;
    int tx_gap_max = 12;
    int rx_gap_max = 12;
    int rx_hold = 0;
    int win_lo = int'(CLIFF_LOW_RST);
    int win_hi = int'(CLIFF_HIGH_RST);
    int quiet_cycles = 0;

    guarded_drive_supervisor dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .target_distance(target_distance), .distance_delta(distance_delta),
        .bump_left(bump_left), .bump_right(bump_right),
        .cliff_front_left(cliff_front_left), .cliff_side_left(cliff_side_left),
        .cliff_front_right(cliff_front_right), .cliff_side_right(cliff_side_right),
        .out_valid(out_valid), .out_ready(out_ready),
        .wheel_speed(wheel_speed), .outcome(outcome), .finished(finished),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    drive_command_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .target_distance(target_distance), .distance_delta(distance_delta),
        .bump_left(bump_left), .bump_right(bump_right),
        .cliff_front_left(cliff_front_left), .cliff_side_left(cliff_side_left),
        .cliff_front_right(cliff_front_right), .cliff_side_right(cliff_side_right),
        .out_valid(out_valid), .out_ready(out_ready),
        .wheel_speed(wheel_speed), .outcome(outcome), .finished(finished),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [CLIFF_W-1:0] safe_signal();
        if (win_lo <= win_hi)
            return CLIFF_W'($urandom_range(win_lo, win_hi));
        return CLIFF_W'($urandom);
    endfunction

    function automatic logic [CLIFF_W-1:0] cliff_signal();
        if (win_lo > 0 && ($urandom_range(0, 1) == 0 || win_hi >= SIGNAL_MAX))
            return CLIFF_W'($urandom_range(0, win_lo - 1));
        if (win_hi < SIGNAL_MAX)
            return CLIFF_W'($urandom_range(win_hi + 1, SIGNAL_MAX));
        return CLIFF_W'($urandom_range(0, SIGNAL_MAX));
    endfunction

    function automatic item_t start_item(input logic signed [DIST_W-1:0] target);
        item_t it;
        it = ITEM_BITS'({$urandom, $urandom, $urandom});
        it.op = OP_START;
        it.target_distance = target;
        return it;
    endfunction

    function automatic item_t sample_item(
        input logic signed [DIST_W-1:0] delta,
        input logic                     bl,
        input logic                     br,
        input logic [CLIFF_W-1:0]       cfl,
        input logic [CLIFF_W-1:0]       csl,
        input logic [CLIFF_W-1:0]       cfr,
        input logic [CLIFF_W-1:0]       csr
    );
        item_t it;
        it.op = OP_SAMPLE;
        it.target_distance = DIST_W'($urandom);
        it.distance_delta = delta;
        it.bump_left = bl;
        it.bump_right = br;
        it.cliff_front_left = cfl;
        it.cliff_side_left = csl;
        it.cliff_front_right = cfr;
        it.cliff_side_right = csr;
        return it;
    endfunction

    function automatic item_t clean_sample(input logic signed [DIST_W-1:0] delta);
        return sample_item(delta, 1'b0, 1'b0, safe_signal(), safe_signal(),
                           safe_signal(), safe_signal());
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op <= it.op;
        target_distance <= it.target_distance;
        distance_delta <= it.distance_delta;
        bump_left <= it.bump_left;
        bump_right <= it.bump_right;
        cliff_front_left <= it.cliff_front_left;
        cliff_side_left <= it.cliff_side_left;
        cliff_front_right <= it.cliff_front_right;
        cliff_side_right <= it.cliff_side_right;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_register(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input int lo, input int hi, input int backup,
                                 input int fwd, input int rev);
        set_register(REG_CLIFF_LOW, lo);
        set_register(REG_CLIFF_HIGH, hi);
        set_register(REG_BACKUP_DISTANCE, backup);
        set_register(REG_FORWARD_SPEED, fwd);
        set_register(REG_REVERSE_SPEED, rev);
        win_lo = lo;
        win_hi = hi;
    endtask

    task automatic random_traffic(input int upto);
        item_t                    it;
        logic signed [DIST_W-1:0] target;
        int                       n;
        int                       hit;
        int                       step;
        int                       pick;
        while (items_sent < upto)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 5))
                begin
                    it = ITEM_BITS'({$urandom, $urandom, $urandom});
                    send_item(it);
                end
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    target = DIST_W'($urandom_range(1, 2000));
                else if (pick < 85)
                    target = DIST_W'($urandom_range(1, 32767));
                else if (pick < 95)
                    target = DIST_W'(-int'($urandom_range(0, 32768)));
                else
                    target = DIST_W'($urandom);
                send_item(start_item(target));
                step = (target > 0) ? target / 6 + 10 : 50;
                n = $urandom_range(1, 30);
                hit = ($urandom_range(0, 1) != 0) ? $urandom_range(0, n - 1) : n;
                for (int k = 0; k < n; k++)
                begin
                    pick = $urandom_range(0, 59);
                    if (k < hit)
                    begin
                        it = clean_sample(DIST_W'($urandom_range(0, step)));
                        if (pick < 6)
                            it.distance_delta = DIST_W'(-int'($urandom_range(0, 50)));
                        else if (pick < 8)
                            it.distance_delta = DIST_W'($urandom);
                    end
                    else if (k == hit)
                    begin
                        it = clean_sample(DIST_W'($urandom_range(0, step)));
                        case ($urandom_range(0, 4))
                            0:
                            begin
                                it.bump_left = 1'b1;
                                it.bump_right = 1'($urandom);
                            end
                            1: it.bump_right = 1'b1;
                            2:
                            begin
                                if ($urandom_range(0, 1) != 0)
                                    it.cliff_front_left = cliff_signal();
                                else
                                    it.cliff_side_left = cliff_signal();
                                if (pick < 20)
                                    it.cliff_side_right = cliff_signal();
                            end
                            3:
                            begin
                                if ($urandom_range(0, 1) != 0)
                                    it.cliff_front_right = cliff_signal();
                                else
                                    it.cliff_side_right = cliff_signal();
                            end
                            default:
                            begin
                                it.bump_left = 1'($urandom);
                                it.bump_right = 1'($urandom);
                                it.cliff_front_left = CLIFF_W'($urandom);
                                it.cliff_side_left = CLIFF_W'($urandom);
                                it.cliff_front_right = CLIFF_W'($urandom);
                                it.cliff_side_right = CLIFF_W'($urandom);
                            end
                        endcase
                    end
                    else
                    begin
                        it = clean_sample(DIST_W'(-int'($urandom_range(0, 80))));
                        if (pick < 3)
                            it.cliff_front_right = cliff_signal();
                        else if (pick < 6)
                            it.cliff_side_left = cliff_signal();
                        else if (pick < 9)
                        begin
                            it.bump_left = 1'($urandom);
                            it.bump_right = 1'b1;
                        end
                        else if (pick < 11)
                            it.distance_delta = DIST_W'($urandom);
                    end
                    send_item(it);
                end
            end
        end
    endtask

    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            gap = $urandom_range(0, rx_gap_max);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(clean_sample(0));
        send_item(start_item(-32768));
        send_item(start_item(0));
        send_item(start_item(32767));
        send_item(sample_item(32767, 1'b1, 1'b1, 0, 4095, 0, 4095));
        send_item(sample_item(-10, 1'b0, 1'b0, 500, 2500, 500, 2500));
        send_item(sample_item(0, 1'b0, 1'b0, 500, 500, 2501, 500));
        send_item(start_item(100));
        send_item(sample_item(20, 1'b0, 1'b1, 499, 1000, 1000, 1000));
        send_item(sample_item(-150, 1'b1, 1'b0, 1000, 1000, 1000, 1000));
        send_item(start_item(100));
        send_item(sample_item(99, 1'b0, 1'b0, 1000, 499, 4095, 1000));
        send_item(clean_sample(-100));
        send_item(clean_sample(-50));
        send_item(start_item(100));
        send_item(sample_item(200, 1'b0, 1'b0, 1000, 1000, 1000, 2501));
        send_item(clean_sample(-32768));
        send_item(start_item(1));
        send_item(start_item(50));
        send_item(clean_sample(49));
        send_item(clean_sample(1));
        send_item(clean_sample(5));

        settle();
        apply_setting(0, SIGNAL_MAX, 32767, 511, 500);
        set_register(REG_SPARE, $urandom);
        send_item(start_item(32767));
        send_item(sample_item(0, 1'b1, 1'b0, 0, 0, 0, 0));
        repeat (4) send_item(clean_sample(32767));
        repeat (4) send_item(clean_sample(-32768));
        send_item(start_item(1));
        repeat (5) send_item(clean_sample(-32768));
        repeat (5) send_item(clean_sample(32767));
        tx_gap_max = 0;
        rx_gap_max = 0;
        random_traffic(items_sent + 150);

        settle();
        apply_setting(SIGNAL_MAX, 0, 0, 0, 0);
        tx_gap_max = 3;
        rx_gap_max = 12;
        random_traffic(items_sent + 120);

        for (int p = 0; p < 6; p++)
        begin
            settle();
            apply_setting($urandom_range(0, 1500), $urandom_range(2000, SIGNAL_MAX),
                          $urandom_range(0, 400), $urandom_range(0, 511),
                          $urandom_range(0, 511));
            tx_gap_max = 4 * $urandom_range(0, 3);
            rx_gap_max = 4 * $urandom_range(0, 3);
            if (p == 1)
            begin
                rx_hold = 300;
                tx_gap_max = 0;
                send_item(start_item(30000));
                repeat (39) send_item(clean_sample(10));
            end
            random_traffic(items_sent + 110);
            if (p == 2)
                settle();
            random_traffic(items_sent + 110);
        end

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
